/* rtl/lfu_pkg.sv */
package lfu_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int DATA_W      = 32;
	localparam int CAP_W       = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [DATA_W-1:0] MISS_VALUE = '1;
	localparam logic [DATA_W-1:0] COUNT_MAX  = '1;

	typedef struct packed {
		logic               command;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} lfu_req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} lfu_rsp_t;

	// one table entry as held in the data memory
	typedef struct packed {
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] key;
	} lfu_entry_t;

endpackage

/* rtl/lfu_ram.sv */
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lfu_cache_table_unit.sv */
// Channel   Dir  Handshake                    Payload
// request   in   start && !busy               lfu_req_t  (command, key, value)
// response  out  done, one cycle, no stall    lfu_rsp_t  (hit, read_value)
// cfg       in   cfg_valid && cfg_ready       cfg_data   (capacity)
//
// busy stays high for one sweep of the entry memories, which finds match, victim
// and free slot, and for a hit or put a second sweep that rewrites ranks; a get
// miss ends after the first. A new command is accepted only once busy drops.
// done is registered from the decide state. Reset clears valid bits and the
// fill level at once, no clearing pass. The receiver cannot stall.
module lfu_cache_table_unit #(
	parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  lfu_pkg::lfu_req_t         request,
	output logic                      done,
	output lfu_pkg::lfu_rsp_t         response,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW   = IW;
	localparam int FW   = $clog2(ENTRIES + 1);
	localparam int XW   = (FW > lfu_pkg::CAP_W) ? FW : lfu_pkg::CAP_W;
	localparam int EW   = $bits(lfu_pkg::lfu_entry_t);
	localparam int DW   = lfu_pkg::DATA_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_UPD    = 4'b1000
	} state_t;

	state_t state_q;

	logic [lfu_pkg::CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [FW-1:0]             fill_q;
	lfu_pkg::lfu_req_t         req_q;

	logic [FW-1:0] rd_cnt_q;
	logic          vld_s1;
	logic          ev_s1;
	logic [IW-1:0] idx_s1;

	logic          found_q, vic_found_q, free_found_q;
	logic [IW-1:0] m_idx_q, vic_idx_q, free_idx_q;
	logic [RW-1:0] m_rank_q, vic_rank_q;
	logic [DW-1:0] m_val_q, m_cnt_q, vic_cnt_q;

	logic [IW-1:0] slot_q;
	logic [RW-1:0] r_q;
	logic          all_q;

	logic              done_q;
	lfu_pkg::lfu_rsp_t rsp_q;

	logic accept;
	logic issue;
	logic sweep_end;
	logic [IW-1:0] rd_idx;

	lfu_pkg::lfu_entry_t ent_rd, ent_wr;
	logic [RW-1:0]       rank_rd, rank_wr;
	logic                ent_we, rank_we;
	logic [IW-1:0]       ent_waddr;

	logic [XW-1:0] cap_x, cap_eff;
	logic          full;
	logic          is_put;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign response  = rsp_q;
	assign rd_idx    = rd_cnt_q[IW-1:0];
	assign issue     = ((state_q == S_SCAN) || (state_q == S_UPD)) && (rd_cnt_q != FW'(ENTRIES));
	assign sweep_end = (rd_cnt_q == FW'(ENTRIES)) && !vld_s1;
	assign is_put    = (req_q.command == lfu_pkg::CMD_PUT);

	// capacity clamped to 1..ENTRIES
	always_comb begin
		cap_x = XW'(cap_q);
		priority if (cap_x == '0) begin
			cap_eff = XW'(1);
		end else if (cap_x > XW'(ENTRIES)) begin
			cap_eff = XW'(ENTRIES);
		end else begin
			cap_eff = cap_x;
		end
	end
	assign full = (XW'(fill_q) >= cap_eff);

	lfu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wr),
		.raddr (rd_idx),
		.rdata (ent_rd)
	);

	lfu_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wr),
		.raddr (rd_idx),
		.rdata (rank_rd)
	);

	// entry write happens at most once, in the decide cycle, and only for a hit or a put
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = free_idx_q;
		ent_wr.key   = req_q.key;
		ent_wr.value = req_q.value;
		ent_wr.count = DW'(1);
		if ((state_q == S_DECIDE) && (found_q || is_put)) begin
			ent_we = 1'b1;
			priority if (found_q) begin
				ent_waddr    = m_idx_q;
				ent_wr.value = is_put ? req_q.value : m_val_q;
				ent_wr.count = (m_cnt_q == lfu_pkg::COUNT_MAX) ? m_cnt_q : m_cnt_q + DW'(1);
			end else if (full) begin
				ent_waddr = vic_idx_q;
			end else begin
				ent_waddr = free_idx_q;
			end
		end
	end

	// rank rewrite: touched slot goes to 0, newer entries move back one.
	// Evict+insert reduces to a touch of the victim's rank.
	always_comb begin
		rank_we = 1'b0;
		rank_wr = '0;
		if ((state_q == S_UPD) && vld_s1) begin
			priority if (idx_s1 == slot_q) begin
				rank_we = 1'b1;
			end else if (ev_s1 && (all_q || (rank_rd < r_q))) begin
				rank_we = 1'b1;
				rank_wr = rank_rd + RW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= lfu_pkg::CAP_RESET;
			valid_q  <= '0;
			fill_q   <= '0;
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			vld_s1 <= issue;
			done_q <= (state_q == S_DECIDE);
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + FW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sweep_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rd_cnt_q <= '0;
					if (!found_q && !is_put) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_UPD;
						if (!found_q && !full) begin
							valid_q[free_idx_q] <= 1'b1;
							fill_q              <= fill_q + FW'(1);
						end
					end
				end
				S_UPD: begin
					if (sweep_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			found_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if ((state_q == S_SCAN) && vld_s1) begin
			if (ev_s1 && (ent_rd.key == req_q.key)) begin
				found_q <= 1'b1;
			end
			if (ev_s1 && (!vic_found_q || (ent_rd.count < vic_cnt_q)
					|| ((ent_rd.count == vic_cnt_q) && (rank_rd > vic_rank_q)))) begin
				vic_found_q <= 1'b1;
			end
			if (!ev_s1) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (issue) begin
			idx_s1 <= rd_idx;
			ev_s1  <= valid_q[rd_idx];
		end
		if ((state_q == S_SCAN) && vld_s1) begin
			if (ev_s1 && !found_q && (ent_rd.key == req_q.key)) begin
				m_idx_q  <= idx_s1;
				m_rank_q <= rank_rd;
				m_val_q  <= ent_rd.value;
				m_cnt_q  <= ent_rd.count;
			end
			if (ev_s1 && (!vic_found_q || (ent_rd.count < vic_cnt_q)
					|| ((ent_rd.count == vic_cnt_q) && (rank_rd > vic_rank_q)))) begin
				vic_idx_q  <= idx_s1;
				vic_cnt_q  <= ent_rd.count;
				vic_rank_q <= rank_rd;
			end
			if (!ev_s1 && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == S_DECIDE) begin
			rsp_q.hit        <= found_q;
			rsp_q.read_value <= (found_q && !is_put) ? m_val_q : lfu_pkg::MISS_VALUE;
			priority if (found_q) begin
				slot_q <= m_idx_q;
				r_q    <= m_rank_q;
				all_q  <= 1'b0;
			end else if (full) begin
				slot_q <= vic_idx_q;
				r_q    <= vic_rank_q;
				all_q  <= 1'b0;
			end else begin
				slot_q <= free_idx_q;
				r_q    <= '0;
				all_q  <= 1'b1;
			end
		end
	end

	// valid bits and fill level move together
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(fill_q))
		else $error("fill level differs from number of valid entries");

	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DECIDE))
		else $error("result strobe without a decide cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("accepted transaction did not raise busy");

	a_rank_write_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rank_we |-> (state_q == S_UPD) && vld_s1 && !ent_we)
		else $error("rank write outside the update sweep");

endmodule

/* test/tb_lfu_cache_table_unit.sv */
`timescale 1ns / 100ps

module tb_lfu_cache_table_unit;
	import lfu_pkg::*;

	localparam int ENTRIES     = ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_MAX    = 20;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	lfu_req_t            request;
	logic                done;
	lfu_rsp_t            response;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data;

	// shadow copy of the cache table
	logic                slot_valid [ENTRIES];
	logic [DATA_W-1:0]   slot_key   [ENTRIES];
	logic [DATA_W-1:0]   slot_value [ENTRIES];
	logic [DATA_W-1:0]   slot_count [ENTRIES];
	int                  slot_rank  [ENTRIES];
	int                  fill_q;
	logic [CAP_W-1:0]    capacity_q;

	lfu_rsp_t            results_due [$];
	lfu_rsp_t            oldest_rsp;
	int                  error_count;
	int                  cycle_count;
	bit                  sender_burst;
	logic [DATA_W-1:0]   key_pool [POOL_MAX];

	lfu_cache_table_unit #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[lfu_cache_table_unit] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < 100)
			$display("mismatch @ cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// use count saturates; the entry becomes most recent
	function automatic void bump_entry(input int s);
		int old_rank;
		if (slot_count[s] != COUNT_MAX)
			slot_count[s]++;
		old_rank = slot_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && i != s && slot_rank[i] < old_rank)
				slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic lfu_rsp_t cache_predict(input lfu_req_t item);
		lfu_rsp_t rsp;
		int hit_slot;
		int slot;
		int limit;
		int old_rank;
		hit_slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit_slot < 0 && slot_valid[i] && slot_key[i] == item.key)
				hit_slot = i;
		limit = (capacity_q == 0) ? 1 : ((capacity_q > ENTRIES) ? ENTRIES : int'(capacity_q));
		rsp.hit = (hit_slot >= 0);
		rsp.read_value = MISS_VALUE;
		if (hit_slot >= 0) begin
			if (item.command == CMD_GET)
				rsp.read_value = slot_value[hit_slot];
			else
				slot_value[hit_slot] = item.value;
			bump_entry(hit_slot);
		end else if (item.command == CMD_PUT) begin
			slot = -1;
			if (fill_q >= limit) begin
				// victim: lowest count, oldest touch among ties
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
					    (slot_count[i] == slot_count[slot] && slot_rank[i] > slot_rank[slot])))
						slot = i;
				end
				if (slot >= 0) begin
					old_rank = slot_rank[slot];
					slot_valid[slot] = 1'b0;
					for (int i = 0; i < ENTRIES; i++)
						if (slot_valid[i] && slot_rank[i] > old_rank)
							slot_rank[i]--;
					if (fill_q > 0)
						fill_q--;
				end
			end
			if (slot < 0) begin
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!slot_valid[i])
						slot = i;
			end
			if (slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_valid[i])
						slot_rank[i]++;
				slot_valid[slot] = 1'b1;
				slot_key[slot]   = item.key;
				slot_value[slot] = item.value;
				slot_count[slot] = 1;
				slot_rank[slot]  = 0;
				fill_q++;
			end
		end
		return rsp;
	endfunction

	// called at a clock edge; returns at the edge that accepts the transaction
	task automatic send_command(input logic cmd, input logic [DATA_W-1:0] key,
	                            input logic [DATA_W-1:0] value);
		lfu_req_t item;
		int gap;
		item.command = cmd;
		item.key     = key;
		item.value   = value;
		gap = sender_burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy);
		results_due.push_back(cache_predict(item));
	endtask

	task automatic idle_sender();
		start <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		idle_sender();
		wait_results_drained();
		// the block rewrites ranks after done; wait until it drops busy
		while (busy)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		capacity_q = cap;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing pending");
			end else begin
				oldest_rsp = results_due.pop_front();
				if (response.hit !== oldest_rsp.hit)
					report_mismatch($sformatf("hit %0b, expected %0b",
					                          response.hit, oldest_rsp.hit));
				if (response.read_value !== oldest_rsp.read_value)
					report_mismatch($sformatf("read_value %h, expected %h",
					                          response.read_value, oldest_rsp.read_value));
			end
		end
	end

	task automatic test_basic_ops();
		sender_burst = 1'b0;
		send_command(CMD_GET, 32'h0000_0000, 32'h1234_5678);   // miss on empty table
		send_command(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_command(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_command(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_command(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_command(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_command(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000);   // update in place
		send_command(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		sender_burst = 1'b1;
		send_command(CMD_PUT, 32'h0000_0000, 32'h0000_0001);
		send_command(CMD_GET, 32'h0000_0001, 32'h0000_0000);
		idle_sender();
	endtask

	// lowered capacity below fill level, capacity zero, capacity beyond the table
	task automatic test_capacity_limits();
		sender_burst = 1'b0;
		write_capacity(5'd2);
		send_command(CMD_PUT, 32'h0000_00A5, 32'h5A5A_5A5A);
		send_command(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_command(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_command(CMD_PUT, 32'h0000_00A6, 32'hA5A5_A5A5);
		write_capacity(5'd0);
		send_command(CMD_PUT, 32'h0000_00B0, 32'h0000_00B0);
		send_command(CMD_PUT, 32'h0000_00B1, 32'h0000_00B1);
		send_command(CMD_GET, 32'h0000_00B0, 32'h0000_0000);
		write_capacity(5'd31);
		for (int i = 0; i < ENTRIES - 1; i++)
			send_command(CMD_PUT, 32'h0000_0C00 + i, $urandom);
		send_command(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		idle_sender();
	endtask

	task automatic random_items(input int count, input int pool_size, input bit with_pauses);
		logic [DATA_W-1:0] key;
		int pick;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 19) == 0)
				sender_burst = !sender_burst;
			if ($urandom_range(0, 6) == 0) begin
				key = $urandom;   // mostly misses
			end else begin
				// skewed pick so use counts spread out
				pick = $urandom_range(0, $urandom_range(0, pool_size - 1));
				key = key_pool[pick];
			end
			send_command($urandom_range(0, 1) ? CMD_PUT : CMD_GET, key, $urandom);
			if (with_pauses && $urandom_range(0, 4) == 0) begin
				idle_sender();
				wait_results_drained();
			end
		end
		idle_sender();
	endtask

	task automatic fill_pool(input int pool_size);
		for (int i = 0; i < pool_size; i++)
			key_pool[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
	endtask

	task automatic test_drain_pause();
		write_capacity(5'd4);
		fill_pool(7);
		random_items(30, 7, 1'b1);
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] cap_list [10];
		int limit;
		int pool_size;
		cap_list = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd5, 5'd0};
		cap_list[9] = $urandom_range(0, 31);
		foreach (cap_list[p]) begin
			write_capacity(cap_list[p]);
			limit = (cap_list[p] == 0) ? 1 : ((cap_list[p] > ENTRIES) ? ENTRIES : cap_list[p]);
			pool_size = limit + $urandom_range(1, 4);
			fill_pool(pool_size);
			random_items(80, pool_size, 1'b0);
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		request     <= '0;
		cfg_valid   <= 1'b0;
		cfg_data    <= CAP_RESET;
		error_count = 0;
		cycle_count = 0;
		sender_burst = 1'b0;
		fill_q      = 0;
		capacity_q  = CAP_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_count[i] = '0;
			slot_rank[i]  = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_limits();
		test_drain_pause();
		test_random_traffic();

		idle_sender();
		wait_results_drained();
		while (busy)
			@(posedge clk);
		repeat (2 * ENTRIES + 8) @(posedge clk);
		if (results_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", results_due.size()));
		if (error_count == 0) begin
			$display("[lfu_cache_table_unit] OK");
		end else begin
			$display("[lfu_cache_table_unit] ERROR");
		end
		$finish;
	end

endmodule
